>>> sv/csim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csim_pkg;
	localparam int ELEMENT_BITS = 16;
	localparam int DOT_BITS     = 42;
	localparam int NORM_BITS    = 41;
	localparam int QUEUE_DEPTH  = 2;

	typedef struct packed {
		logic signed [DOT_BITS-1:0] dot;
		logic [NORM_BITS-1:0]       n1;
		logic [NORM_BITS-1:0]       n2;
	} csim_sums_t;
endpackage
`default_nettype wire

>>> sv/csim_front.sv
`timescale 1ns / 1ps
`default_nettype none
module csim_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [15:0]  first_value,
	input  wire logic signed [15:0]  second_value,
	input  wire logic                last,
	input  wire logic                full,
	output logic                     push,
	output csim_pkg::csim_sums_t     push_sums
);
	logic signed [41:0] dot_q;
	logic [40:0]        n1_q;
	logic [40:0]        n2_q;
	logic signed [31:0] p_ab;
	logic signed [31:0] p_aa;
	logic signed [31:0] p_bb;
	logic signed [42:0] dot_ext;
	logic [41:0]        n1_ext;
	logic [41:0]        n2_ext;
	logic               accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last;

	always_comb begin
		p_ab    = first_value * second_value;
		p_aa    = first_value * first_value;
		p_bb    = second_value * second_value;
		dot_ext = 43'(dot_q) + 43'(p_ab);
		n1_ext  = {1'b0, n1_q} + {10'b0, p_aa};
		n2_ext  = {1'b0, n2_q} + {10'b0, p_bb};
		// clamp to the accumulator range
		if (dot_ext[42] != dot_ext[41])
			push_sums.dot = dot_ext[42] ? {1'b1, 41'b0} : {1'b0, {41{1'b1}}};
		else
			push_sums.dot = dot_ext[41:0];
		push_sums.n1 = n1_ext[41] ? {41{1'b1}} : n1_ext[40:0];
		push_sums.n2 = n2_ext[41] ? {41{1'b1}} : n2_ext[40:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			n1_q  <= '0;
			n2_q  <= '0;
		end else if (accept) begin
			if (last) begin
				dot_q <= '0;
				n1_q  <= '0;
				n2_q  <= '0;
			end else begin
				dot_q <= push_sums.dot;
				n1_q  <= push_sums.n1;
				n2_q  <= push_sums.n2;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/csim_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module csim_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire csim_pkg::csim_sums_t wr_data,
	input  wire logic                 pop,
	output csim_pkg::csim_sums_t      rd_data,
	output logic                      full,
	output logic                      empty
);
	localparam int AW = $clog2(csim_pkg::QUEUE_DEPTH);

	csim_pkg::csim_sums_t mem [csim_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full    = count_q == (AW+1)'(csim_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == AW'(csim_pkg::QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == AW'(csim_pkg::QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

>>> sv/csim_back.sv
`timescale 1ns / 1ps
`default_nettype none
module csim_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 empty,
	input  wire csim_pkg::csim_sums_t rd_data,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [15:0]               cosine,
	output logic                      zero_norm
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MULP, ST_MULM, ST_DIV, ST_SQRT, ST_DONE
	} state_t;

	state_t         state_q;
	logic [5:0]     cnt_q;
	logic [41:0]    mcand_q;
	logic [83:0]    mp_q;
	logic [81:0]    prod_q;
	logic [41:0]    mag_q;
	logic [113:0]   rem_q;
	logic [113:0]   dsh_q;
	logic [30:0]    x_q;
	logic           ovf_q;
	logic [15:0]    root_q;
	logic           neg_q;
	logic           zero_q;

	logic [42:0]    mul_sum;
	logic [83:0]    mp_next;
	logic           ge;
	logic [30:0]    x_eff;
	logic [15:0]    trial;
	logic [31:0]    trial_sq;
	logic [16:0]    qc;
	logic [15:0]    result;

	assign pop = (state_q == ST_IDLE) && !empty;

	always_comb begin
		// one shift-add step of the shared multiplier
		mul_sum  = {1'b0, mp_q[83:42]} + (mp_q[0] ? {1'b0, mcand_q} : 43'd0);
		mp_next  = {mul_sum, mp_q[41:1]};
		ge       = rem_q >= dsh_q;
		// a quotient past 31 bits takes the root from the largest 31-bit value
		x_eff    = ovf_q ? '1 : x_q;
		trial    = root_q | (16'd1 << cnt_q[3:0]);
		trial_sq = trial * trial;
		qc       = (root_q > 16'd32768) ? 17'd32768 : {1'b0, root_q};
		if (neg_q)
			result = 16'(17'd0 - qc);
		else
			result = (qc > 17'd32767) ? 16'd32767 : qc[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						neg_q   <= rd_data.dot[41];
						mag_q   <= rd_data.dot[41] ? 42'(-rd_data.dot) : rd_data.dot;
						mcand_q <= {1'b0, rd_data.n1};
						mp_q    <= {43'b0, rd_data.n2};
						cnt_q   <= 6'd41;
						root_q  <= '0;
						if (rd_data.n1 == '0 || rd_data.n2 == '0) begin
							zero_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							zero_q  <= 1'b0;
							state_q <= ST_MULP;
						end
					end
				end
				ST_MULP: begin
					if (cnt_q == '0) begin
						prod_q  <= mp_next[81:0];
						mcand_q <= mag_q;
						mp_q    <= {42'b0, mag_q};
						cnt_q   <= 6'd41;
						state_q <= ST_MULM;
					end else begin
						mp_q  <= mp_next;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_MULM: begin
					if (cnt_q == '0) begin
						rem_q   <= {mp_next, 30'b0};
						dsh_q   <= {1'b0, prod_q, 31'b0};
						x_q     <= '0;
						cnt_q   <= 6'd31;
						state_q <= ST_DIV;
					end else begin
						mp_q  <= mp_next;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV: begin
					// first compare only detects a quotient past 31 bits
					if (cnt_q == 6'd31) begin
						ovf_q <= ge;
					end else if (ge) begin
						rem_q            <= rem_q - dsh_q;
						x_q[cnt_q[4:0]]  <= 1'b1;
					end
					dsh_q <= dsh_q >> 1;
					if (cnt_q == '0) begin
						cnt_q   <= 6'd15;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (trial_sq <= {1'b0, x_eff})
						root_q <= trial;
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						cosine    <= zero_q ? 16'd0 : result;
						zero_norm <= zero_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/cosine_similarity_engine.sv
// Result path: after the edge that accepts the last pair, the sums are queued and popped, then
// pass two 42-step multiplies, a 32-step divide and a 16-step root before m_axis_tvalid rises.
// Throughput: one element pair per cycle while the two-entry queue has room; results are computed
// one at a time by the shared shift-add multiplier and the bit-serial divider and root.
// Reset: arst_n clears accumulators, queue and output valid asynchronously.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // first_value[15:0], second_value[31:16]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // cosine[15:0]
	output logic             m_axis_tuser   // zero_norm[0]
);
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	csim_pkg::csim_sums_t push_sums;
	csim_pkg::csim_sums_t rd_data;

	csim_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.first_value  (s_axis_tdata[15:0]),
		.second_value (s_axis_tdata[31:16]),
		.last         (s_axis_tlast),
		.full         (full),
		.push         (push),
		.push_sums    (push_sums)
	);

	csim_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_sums),
		.pop     (pop),
		.rd_data (rd_data),
		.full    (full),
		.empty   (empty)
	);

	csim_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.rd_data   (rd_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cosine    (m_axis_tdata),
		.zero_norm (m_axis_tuser)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> full) else $error("input stalled with queue space");
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'd0))
		else $error("zero norm with nonzero cosine");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
endmodule
`default_nettype wire
